@@ rtl/bqm_pkg.sv @@
// ----------------------------------------------------------------------------
// bqm_pkg
// Shared widths, constants and control types of the bilinear quad map unit.
// ----------------------------------------------------------------------------
package bqm_pkg;

  // reference coordinates are signed Q2.14
  localparam int REF_W     = 16;
  // hat weights 1 -/+ ref need one more bit than the reference
  localparam int WEIGHT_W  = REF_W + 1;
  // fraction bits of a Q16.16 coordinate
  localparam int FRAC_BITS = 16;
  // the point sum carries two Q2.14 weights on top of Q16.16, plus the
  // quarter that turns the product of two (1 -/+ ref) factors into a weight
  localparam int PT_SHIFT  = 2 * (REF_W - 2) + 2;
  // Jacobian determinant is Q32.32
  localparam int DET_W     = 64;
  // register stages from input to output register
  localparam int NUM_STAGES = 6;

  // 1.0 in Q2.14
  localparam logic signed [WEIGHT_W-1:0] REF_ONE = WEIGHT_W'(16384);

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } stage_ctrl_t;

endpackage

@@ rtl/bqm_intf.sv @@
// ----------------------------------------------------------------------------
// bqm channel interfaces
// Valid/ready channels for the reference point plus corners and the result.
// ----------------------------------------------------------------------------
interface bqm_in_if #(
  parameter int COORD_WIDTH = 32
);
  import bqm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [REF_W-1:0]       ref_xi;
  logic signed [REF_W-1:0]       ref_eta;
  logic signed [COORD_WIDTH-1:0] corner0_x;
  logic signed [COORD_WIDTH-1:0] corner0_y;
  logic signed [COORD_WIDTH-1:0] corner1_x;
  logic signed [COORD_WIDTH-1:0] corner1_y;
  logic signed [COORD_WIDTH-1:0] corner2_x;
  logic signed [COORD_WIDTH-1:0] corner2_y;
  logic signed [COORD_WIDTH-1:0] corner3_x;
  logic signed [COORD_WIDTH-1:0] corner3_y;

  modport source (
    output valid, ref_xi, ref_eta, corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, corner3_x, corner3_y,
    input  ready
  );

  modport sink (
    input  valid, ref_xi, ref_eta, corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, corner3_x, corner3_y,
    output ready
  );
endinterface

interface bqm_out_if #(
  parameter int COORD_WIDTH = 32
);
  import bqm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] mapped_x;
  logic signed [COORD_WIDTH-1:0] mapped_y;
  logic signed [DET_W-1:0]       jacobian_det;

  modport source (
    output valid, mapped_x, mapped_y, jacobian_det,
    input  ready
  );

  modport sink (
    input  valid, mapped_x, mapped_y, jacobian_det,
    output ready
  );
endinterface

@@ rtl/bqm_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// bqm_pipe_ctrl
// Valid bits and per-stage load enables; bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module bqm_pipe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bqm_pkg::stage_ctrl_t ctrl
);
  import bqm_pkg::*;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] en;

  // a stage loads when it is empty or its word moves on
  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctrl.en   = en;
  assign in_ready  = en[0];
  assign out_valid = vld_r[NUM_STAGES-1];

endmodule

@@ rtl/bqm_front.sv @@
// ----------------------------------------------------------------------------
// bqm_front
// Stage 1: hat weights from the reference point and the corner differences.
// ----------------------------------------------------------------------------
module bqm_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                 clk,
  input  bqm_pkg::stage_ctrl_t                 ctrl,
  input  logic signed [bqm_pkg::REF_W-1:0]     ref_xi,
  input  logic signed [bqm_pkg::REF_W-1:0]     ref_eta,
  input  logic signed [COORD_WIDTH-1:0]        cx [4],
  input  logic signed [COORD_WIDTH-1:0]        cy [4],
  output logic signed [bqm_pkg::WEIGHT_W-1:0]  wa_r,
  output logic signed [bqm_pkg::WEIGHT_W-1:0]  wb_r,
  output logic signed [bqm_pkg::WEIGHT_W-1:0]  va_r,
  output logic signed [bqm_pkg::WEIGHT_W-1:0]  vb_r,
  output logic signed [COORD_WIDTH-1:0]        cx_r [4],
  output logic signed [COORD_WIDTH-1:0]        cy_r [4],
  output logic signed [COORD_WIDTH:0]          dx_r [4],
  output logic signed [COORD_WIDTH:0]          dy_r [4]
);
  import bqm_pkg::*;

  localparam int DIFF_W = COORD_WIDTH + 1;

  logic signed [WEIGHT_W-1:0] xi_ext;
  logic signed [WEIGHT_W-1:0] eta_ext;
  logic signed [DIFF_W-1:0]   cx_ext [4];
  logic signed [DIFF_W-1:0]   cy_ext [4];

  assign xi_ext  = {ref_xi[REF_W-1], ref_xi};
  assign eta_ext = {ref_eta[REF_W-1], ref_eta};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cx_ext[k] = {cx[k][COORD_WIDTH-1], cx[k]};
      cy_ext[k] = {cy[k][COORD_WIDTH-1], cy[k]};
    end
  end

  // weights and edge differences: lower, upper, left, right edge
  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      wa_r <= REF_ONE - xi_ext;
      wb_r <= REF_ONE + xi_ext;
      va_r <= REF_ONE - eta_ext;
      vb_r <= REF_ONE + eta_ext;
      cx_r <= cx;
      cy_r <= cy;
      dx_r[0] <= cx_ext[1] - cx_ext[0];
      dx_r[1] <= cx_ext[2] - cx_ext[3];
      dx_r[2] <= cx_ext[3] - cx_ext[0];
      dx_r[3] <= cx_ext[2] - cx_ext[1];
      dy_r[0] <= cy_ext[1] - cy_ext[0];
      dy_r[1] <= cy_ext[2] - cy_ext[3];
      dy_r[2] <= cy_ext[3] - cy_ext[0];
      dy_r[3] <= cy_ext[2] - cy_ext[1];
    end
  end

endmodule

@@ rtl/bqm_point_path.sv @@
// ----------------------------------------------------------------------------
// bqm_point_path
// Stages 2 to 6: bilinear interpolation, rounding and saturation of the point.
// ----------------------------------------------------------------------------
module bqm_point_path #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk,
  input  bqm_pkg::stage_ctrl_t                ctrl,
  input  logic signed [bqm_pkg::WEIGHT_W-1:0] wa,
  input  logic signed [bqm_pkg::WEIGHT_W-1:0] wb,
  input  logic signed [bqm_pkg::WEIGHT_W-1:0] va,
  input  logic signed [bqm_pkg::WEIGHT_W-1:0] vb,
  input  logic signed [COORD_WIDTH-1:0]       cx [4],
  input  logic signed [COORD_WIDTH-1:0]       cy [4],
  output logic signed [COORD_WIDTH-1:0]       mapped_x,
  output logic signed [COORD_WIDTH-1:0]       mapped_y
);
  import bqm_pkg::*;

  localparam int PAIR_W = WEIGHT_W + COORD_WIDTH + 1;
  localparam int PT_W   = WEIGHT_W + PAIR_W + 1;
  localparam int RND_W  = PT_W + 1 - PT_SHIFT;
  localparam logic signed [PT_W:0] PT_HALF = (PT_W + 1)'(1) << (PT_SHIFT - 1);

  // round half up is done; clamp to the coordinate range
  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [RND_W-1:0] v
  );
    logic [RND_W-COORD_WIDTH:0] hi_bits;
    hi_bits = v[RND_W-1:COORD_WIDTH-1];
    if (hi_bits == '0 || hi_bits == '1) begin
      return v[COORD_WIDTH-1:0];
    end else if (v[RND_W-1]) begin
      return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

  logic signed [PAIR_W-1:0]      lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic signed [PAIR_W-1:0]      lo_x_nxt, hi_x_nxt, lo_y_nxt, hi_y_nxt;
  logic signed [WEIGHT_W-1:0]    va_r, vb_r;
  logic signed [PT_W-1:0]        px_r, py_r, px_nxt, py_nxt;
  logic signed [PT_W:0]          px_adj, py_adj;
  logic signed [COORD_WIDTH-1:0] sx_r, sy_r, mx5_r, my5_r, mx6_r, my6_r;

  // stage 2: interpolate along the lower and upper edges in xi
  assign lo_x_nxt = wa * cx[0] + wb * cx[1];
  assign hi_x_nxt = wb * cx[2] + wa * cx[3];
  assign lo_y_nxt = wa * cy[0] + wb * cy[1];
  assign hi_y_nxt = wb * cy[2] + wa * cy[3];

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      lo_x_r <= lo_x_nxt;
      hi_x_r <= hi_x_nxt;
      lo_y_r <= lo_y_nxt;
      hi_y_r <= hi_y_nxt;
      va_r   <= va;
      vb_r   <= vb;
    end
  end

  // stage 3: blend the lower and upper edges in eta, exact sum
  assign px_nxt = va_r * lo_x_r + vb_r * hi_x_r;
  assign py_nxt = va_r * lo_y_r + vb_r * hi_y_r;

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
  end

  // stage 4: round to Q16.16 and saturate
  assign px_adj = $signed({px_r[PT_W-1], px_r}) + PT_HALF;
  assign py_adj = $signed({py_r[PT_W-1], py_r}) + PT_HALF;

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      sx_r <= sat_coord(px_adj[PT_W:PT_SHIFT]);
      sy_r <= sat_coord(py_adj[PT_W:PT_SHIFT]);
    end
  end

  // stages 5 and 6: wait for the determinant
  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      mx5_r <= sx_r;
      my5_r <= sy_r;
    end
    if (ctrl.en[5]) begin
      mx6_r <= mx5_r;
      my6_r <= my5_r;
    end
  end

  assign mapped_x = mx6_r;
  assign mapped_y = my6_r;

endmodule

@@ rtl/bqm_jac_path.sv @@
// ----------------------------------------------------------------------------
// bqm_jac_path
// Stages 2 to 6: derivatives from edge differences and the 2x2 determinant.
// ----------------------------------------------------------------------------
module bqm_jac_path #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk,
  input  bqm_pkg::stage_ctrl_t                ctrl,
  input  logic signed [bqm_pkg::WEIGHT_W-1:0] wa,
  input  logic signed [bqm_pkg::WEIGHT_W-1:0] wb,
  input  logic signed [bqm_pkg::WEIGHT_W-1:0] va,
  input  logic signed [bqm_pkg::WEIGHT_W-1:0] vb,
  input  logic signed [COORD_WIDTH:0]         dx [4],
  input  logic signed [COORD_WIDTH:0]         dy [4],
  output logic signed [bqm_pkg::DET_W-1:0]    jacobian_det
);
  import bqm_pkg::*;

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int DSUM_W = WEIGHT_W + DIFF_W + 1;
  localparam int DER_W  = DSUM_W + 1 - FRAC_BITS;
  localparam int LO_W   = DER_W / 2;
  localparam int HI_W   = DER_W - LO_W;
  localparam int PH_W   = DER_W + HI_W;
  localparam int PL_W   = DER_W + LO_W + 1;
  localparam int PROD_W = 2 * DER_W;
  localparam int DF_W   = PROD_W + 1;
  localparam logic signed [DSUM_W:0] D_HALF = (DSUM_W + 1)'(1) << (FRAC_BITS - 1);

  logic signed [DSUM_W-1:0] dxi_x_s_r, dxi_y_s_r, deta_x_s_r, deta_y_s_r;
  logic signed [DSUM_W:0]   dxi_x_adj, dxi_y_adj, deta_x_adj, deta_y_adj;
  logic signed [DER_W-1:0]  dxi_x_r, dxi_y_r, deta_x_r, deta_y_r;
  logic signed [PH_W-1:0]   p1h_r, p2h_r, p1h_nxt, p2h_nxt;
  logic signed [PL_W-1:0]   p1l_r, p2l_r, p1l_nxt, p2l_nxt;
  logic signed [PROD_W-1:0] t1_r, t2_r, t1_nxt, t2_nxt;
  logic signed [DF_W-1:0]   diff;
  logic signed [DET_W-1:0]  det_nxt, det_r;

  // stage 2: weighted sums of opposite edge differences
  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      dxi_x_s_r  <= va * dx[0] + vb * dx[1];
      dxi_y_s_r  <= va * dy[0] + vb * dy[1];
      deta_x_s_r <= wa * dx[2] + wb * dx[3];
      deta_y_s_r <= wa * dy[2] + wb * dy[3];
    end
  end

  // stage 3: round each derivative to Q16.16, no clamp
  assign dxi_x_adj  = $signed({dxi_x_s_r[DSUM_W-1], dxi_x_s_r}) + D_HALF;
  assign dxi_y_adj  = $signed({dxi_y_s_r[DSUM_W-1], dxi_y_s_r}) + D_HALF;
  assign deta_x_adj = $signed({deta_x_s_r[DSUM_W-1], deta_x_s_r}) + D_HALF;
  assign deta_y_adj = $signed({deta_y_s_r[DSUM_W-1], deta_y_s_r}) + D_HALF;

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      dxi_x_r  <= dxi_x_adj[DSUM_W:FRAC_BITS];
      dxi_y_r  <= dxi_y_adj[DSUM_W:FRAC_BITS];
      deta_x_r <= deta_x_adj[DSUM_W:FRAC_BITS];
      deta_y_r <= deta_y_adj[DSUM_W:FRAC_BITS];
    end
  end

  // stage 4: partial products, second factor split into high and low halves
  assign p1h_nxt = dxi_x_r * $signed(deta_y_r[DER_W-1:LO_W]);
  assign p1l_nxt = dxi_x_r * $signed({1'b0, deta_y_r[LO_W-1:0]});
  assign p2h_nxt = dxi_y_r * $signed(deta_x_r[DER_W-1:LO_W]);
  assign p2l_nxt = dxi_y_r * $signed({1'b0, deta_x_r[LO_W-1:0]});

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      p1h_r <= p1h_nxt;
      p1l_r <= p1l_nxt;
      p2h_r <= p2h_nxt;
      p2l_r <= p2l_nxt;
    end
  end

  // stage 5: merge the halves into full products
  assign t1_nxt = $signed({p1h_r, {LO_W{1'b0}}})
                + $signed({{(PROD_W-PL_W){p1l_r[PL_W-1]}}, p1l_r});
  assign t2_nxt = $signed({p2h_r, {LO_W{1'b0}}})
                + $signed({{(PROD_W-PL_W){p2l_r[PL_W-1]}}, p2l_r});

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      t1_r <= t1_nxt;
      t2_r <= t2_nxt;
    end
  end

  // stage 6: cross difference, clamped to Q32.32 when wider than that, else sign-extended
  assign diff = $signed({t1_r[PROD_W-1], t1_r}) - $signed({t2_r[PROD_W-1], t2_r});

  if (DF_W >= DET_W) begin : g_sat
    logic [DF_W-DET_W:0] hi_bits;
    assign hi_bits = diff[DF_W-1:DET_W-1];
    always_comb begin
      if (hi_bits == '0 || hi_bits == '1) begin
        det_nxt = diff[DET_W-1:0];
      end else if (diff[DF_W-1]) begin
        det_nxt = {1'b1, {(DET_W-1){1'b0}}};
      end else begin
        det_nxt = {1'b0, {(DET_W-1){1'b1}}};
      end
    end
  end else begin : g_ext
    assign det_nxt = {{(DET_W-DF_W){diff[DF_W-1]}}, diff};
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[5]) begin
      det_r <= det_nxt;
    end
  end

  assign jacobian_det = det_r;

endmodule

@@ rtl/bilinear_quad_map_jacobian_unit.sv @@
// ----------------------------------------------------------------------------
// bilinear_quad_map_jacobian_unit
// Bilinear quadrilateral map of a reference point with Jacobian determinant.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan takes one word per point: ref_xi, ref_eta (Q2.14) and the four
//   corners counterclockwise from lower left (Q16.16). out_chan returns one
//   word per input word, in order: mapped_x, mapped_y (Q16.16, saturated)
//   and jacobian_det (Q32.32, saturated).
//   Six register stages carry each word from the accepting edge to
//   out_chan.valid (weights and differences, edge products, blend and
//   derivative rounding, split determinant products, product merge, cross
//   difference and clamp); throughput is one word per cycle while
//   out_chan.ready does not stall.
//   Each stage loads when it is empty or its word moves on, so a stall on
//   out_chan.ready holds the result and lets earlier words close up the
//   bubbles behind it; in_chan.ready drops only once all six stages are full
//   and the result is still not taken. Nothing is lost or repeated.
//   Reset (rst_n low, synchronous) clears the valid bits; no state is kept
//   between words, so the block is ready once the valid bits are clear.
// ----------------------------------------------------------------------------
module bilinear_quad_map_jacobian_unit #(
  parameter int COORD_WIDTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  bqm_in_if.sink    in_chan,
  bqm_out_if.source out_chan
);
  import bqm_pkg::*;

  stage_ctrl_t ctrl;

  logic signed [COORD_WIDTH-1:0] cx [4];
  logic signed [COORD_WIDTH-1:0] cy [4];
  logic signed [WEIGHT_W-1:0]    wa, wb, va, vb;
  logic signed [COORD_WIDTH-1:0] cx_s1 [4];
  logic signed [COORD_WIDTH-1:0] cy_s1 [4];
  logic signed [COORD_WIDTH:0]   dx_s1 [4];
  logic signed [COORD_WIDTH:0]   dy_s1 [4];

  // corner fields as arrays
  assign cx[0] = in_chan.corner0_x;
  assign cx[1] = in_chan.corner1_x;
  assign cx[2] = in_chan.corner2_x;
  assign cx[3] = in_chan.corner3_x;
  assign cy[0] = in_chan.corner0_y;
  assign cy[1] = in_chan.corner1_y;
  assign cy[2] = in_chan.corner2_y;
  assign cy[3] = in_chan.corner3_y;

  // handshake and stage enables
  bqm_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .ctrl      (ctrl)
  );

  // stage 1
  bqm_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk     (clk),
    .ctrl    (ctrl),
    .ref_xi  (in_chan.ref_xi),
    .ref_eta (in_chan.ref_eta),
    .cx      (cx),
    .cy      (cy),
    .wa_r    (wa),
    .wb_r    (wb),
    .va_r    (va),
    .vb_r    (vb),
    .cx_r    (cx_s1),
    .cy_r    (cy_s1),
    .dx_r    (dx_s1),
    .dy_r    (dy_s1)
  );

  // mapped point
  bqm_point_path #(.COORD_WIDTH(COORD_WIDTH)) u_point (
    .clk      (clk),
    .ctrl     (ctrl),
    .wa       (wa),
    .wb       (wb),
    .va       (va),
    .vb       (vb),
    .cx       (cx_s1),
    .cy       (cy_s1),
    .mapped_x (out_chan.mapped_x),
    .mapped_y (out_chan.mapped_y)
  );

  // Jacobian determinant
  bqm_jac_path #(.COORD_WIDTH(COORD_WIDTH)) u_jac (
    .clk          (clk),
    .ctrl         (ctrl),
    .wa           (wa),
    .wb           (wb),
    .va           (va),
    .vb           (vb),
    .dx           (dx_s1),
    .dy           (dy_s1),
    .jacobian_det (out_chan.jacobian_det)
  );

endmodule

@@ rtl/bqm_port_chk.sv @@
// ----------------------------------------------------------------------------
// bqm_port_chk
// Port-level checks of occupancy and back-pressure, bound to the top level.
// ----------------------------------------------------------------------------
module bqm_port_chk #(
  parameter int COORD_WIDTH = 32
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [COORD_WIDTH-1:0]     out_mapped_x,
  input logic signed [COORD_WIDTH-1:0]     out_mapped_y,
  input logic signed [bqm_pkg::DET_W-1:0]  out_jacobian_det
);
  import bqm_pkg::*;

  localparam int OCC_W = $clog2(NUM_STAGES + 2);

  logic             in_acc;
  logic             out_acc;
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign occ_nxt = occ_r + OCC_W'(in_acc) - OCC_W'(out_acc);

  // words accepted and not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mapped_x)
      && $stable(out_mapped_y) && $stable(out_jacobian_det))
    else $error("stalled result changed");

  // input backs up only when every stage is full and the result is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready && occ_r == NUM_STAGES)
    else $error("input stalled with room in the pipeline");

  // never more words in flight than stages
  a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= NUM_STAGES)
    else $error("more words in flight than stages");

  // no result without a pending word
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != 0)
    else $error("result shown with no word in flight");

endmodule

bind bilinear_quad_map_jacobian_unit bqm_port_chk #(.COORD_WIDTH(COORD_WIDTH)) u_port_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_mapped_x     (out_chan.mapped_x),
  .out_mapped_y     (out_chan.mapped_y),
  .out_jacobian_det (out_chan.jacobian_det)
);
